### rtl/core/matrix_multiply_engine_core_macros.svh
// Assertion macros used by the matrix multiply engine's command queue.
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define MME_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MME_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

### rtl/core/mme_pkg.sv
package mme_pkg;

   localparam int MME_MAX_DIM   = 16;
   localparam int FRAC_BITS     = 15;
   localparam int ELEM_W        = FRAC_BITS + 1;
   localparam int PROD_W        = 2 * ELEM_W;
   localparam int VALUE_W       = 40;
   localparam int IDX_W         = 4;
   localparam int CSR_W         = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int OP_W          = 2;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CSR_W-1:0] DIM_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OP_W-1:0] OP_ROW     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLUMNS  = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE_A,
      CMD_WRITE_B,
      CMD_ROW,
      CMD_ROW_ERR
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   typedef struct packed {
      logic [CSR_W-1:0] m;
      logic [CSR_W-1:0] n;
      logic [CSR_W-1:0] o;
   } dims_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [ELEM_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
      logic signed [VALUE_W-1:0] product_value;
      logic                      row_last;
      logic                      status;
   } rsp_word_type;

   // Register values of zero act as one; values above the store size are clamped.
   function automatic logic [CSR_W-1:0] eff_dim(input logic [CSR_W-1:0] v,
                                                input int max_dim);
      logic [CSR_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CSR_W'(1);
      end else if (int'(v) > max_dim) begin
         r = CSR_W'(max_dim);
      end
      return r;
   endfunction

endpackage

### rtl/core/mme_front.sv
module mme_front
   import mme_pkg::*;
(
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  dims_type                 dims,
   input  logic                     q_full,
   output logic                     q_push,
   output cmd_type                  q_cmd
);

   logic [CSR_W-1:0] row_ext;
   logic [CSR_W-1:0] col_ext;
   logic             keep;

   assign row_ext   = {1'b0, req_row_index};
   assign col_ext   = {1'b0, req_col_index};
   assign req_ready = !q_full;

   // Writes outside the configured shape and the unused operation code are dropped here.
   always_comb begin
      keep        = 1'b0;
      q_cmd.kind  = CMD_ROW;
      q_cmd.row   = req_row_index;
      q_cmd.col   = req_col_index;
      q_cmd.value = req_element_value;
      case (req_operation)
         OP_WRITE_A: begin
            q_cmd.kind = CMD_WRITE_A;
            keep       = (row_ext < dims.m) && (col_ext < dims.n);
         end
         OP_WRITE_B: begin
            q_cmd.kind = CMD_WRITE_B;
            keep       = (row_ext < dims.n) && (col_ext < dims.o);
         end
         OP_ROW: begin
            q_cmd.kind = (row_ext < dims.m) ? CMD_ROW : CMD_ROW_ERR;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_valid && req_ready && keep;

endmodule

### rtl/core/mme_queue.sv
`include "matrix_multiply_engine_core_macros.svh"

module mme_queue
   import mme_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd,
   output logic    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `MME_ASSERT_NEVER(a_no_push_full, clock, reset, push && full, "push into a full queue")
   `MME_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !head_valid, "pop from an empty queue")
   `MME_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue overfilled")

endmodule

### rtl/core/mme_back.sv
module mme_back
   import mme_pkg::*;
#(
   parameter int MAX_DIM = MME_MAX_DIM
) (
   input  logic         clock,
   input  logic         reset,
   input  dims_type     dims,
   input  logic         q_valid,
   input  cmd_type      q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             row_end;
      logic             err;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mac_tag_type;

   back_state_type state_ff;
   back_state_type state_in;

   logic signed [ELEM_W-1:0]  a_mem_ff [MEM_DEPTH];
   logic signed [ELEM_W-1:0]  b_mem_ff [MEM_DEPTH];
   logic signed [ELEM_W-1:0]  a_rd_ff;
   logic signed [ELEM_W-1:0]  b_rd_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [VALUE_W-1:0] acc_ff;
   logic signed [VALUE_W-1:0] acc_base;
   logic signed [VALUE_W-1:0] sum_in;

   logic [IDX_W-1:0] row_ff;
   logic [CSR_W-1:0] j_ff;
   logic [CSR_W-1:0] k_ff;
   logic             k_end;
   logic             j_end;

   logic        s1_vld_ff;
   mac_tag_type s1_tag_ff;
   logic        s2_vld_ff;
   mac_tag_type s2_tag_ff;
   logic        out_vld_ff;
   rsp_word_type out_ff;

   logic        adv;
   logic        a_we;
   logic        b_we;
   logic        start_row;
   logic        step;
   logic        issue;
   mac_tag_type issue_tag;

   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] a_rd_addr;
   logic [ADDR_W-1:0] b_rd_addr;

   // The whole multiply pipeline moves only when the output register can take a word.
   assign adv   = !out_vld_ff || rsp_ready;
   assign k_end = (k_ff == dims.n - CSR_W'(1));
   assign j_end = (j_ff == dims.o - CSR_W'(1));

   assign wr_addr   = ADDR_W'(q_cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(q_cmd.col);
   assign a_rd_addr = ADDR_W'(row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff);
   assign b_rd_addr = ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(j_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && (q_cmd.kind == CMD_ROW)) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (adv && k_end && j_end) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      a_we      = 1'b0;
      b_we      = 1'b0;
      start_row = 1'b0;
      step      = 1'b0;
      issue     = 1'b0;
      issue_tag = '{first: 1'b1, last_k: 1'b1, row_end: 1'b1, err: 1'b1,
                    row: q_cmd.row, col: '0};
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  CMD_WRITE_A: begin
                     a_we  = 1'b1;
                     q_pop = 1'b1;
                  end
                  CMD_WRITE_B: begin
                     b_we  = 1'b1;
                     q_pop = 1'b1;
                  end
                  CMD_ROW: begin
                     start_row = 1'b1;
                     q_pop     = 1'b1;
                  end
                  CMD_ROW_ERR: begin
                     if (adv) begin
                        issue = 1'b1;
                        q_pop = 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_RUN: begin
            if (adv) begin
               issue     = 1'b1;
               step      = 1'b1;
               issue_tag = '{first: (k_ff == '0), last_k: k_end, row_end: j_end,
                             err: 1'b0, row: row_ff, col: IDX_W'(j_ff)};
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_row) begin
         row_ff <= q_cmd.row;
         j_ff   <= '0;
         k_ff   <= '0;
      end else if (step) begin
         if (k_end) begin
            k_ff <= '0;
            j_ff <= j_ff + CSR_W'(1);
         end else begin
            k_ff <= k_ff + CSR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem_ff[wr_addr] <= q_cmd.value;
      end
      if (b_we) begin
         b_mem_ff[wr_addr] <= q_cmd.value;
      end
      if (step) begin
         a_rd_ff <= a_mem_ff[a_rd_addr];
         b_rd_ff <= b_mem_ff[b_rd_addr];
      end
   end

   assign prod_in  = a_rd_ff * b_rd_ff;
   assign acc_base = s2_tag_ff.first ? '0 : acc_ff;
   assign sum_in   = acc_base + {{(VALUE_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= issue;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff && s2_tag_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= prod_in;
         if (s2_vld_ff) begin
            acc_ff <= sum_in;
         end
         if (s2_vld_ff && s2_tag_ff.last_k) begin
            out_ff.out_row       <= s2_tag_ff.row;
            out_ff.out_col       <= s2_tag_ff.col;
            out_ff.product_value <= s2_tag_ff.err ? '0 : sum_in;
            out_ff.row_last      <= s2_tag_ff.row_end;
            out_ff.status        <= s2_tag_ff.err;
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

### rtl/core/matrix_multiply_engine_core.sv
// Dense matrix multiply engine, C = A x B, on signed Q1.15 elements.
// Request channel (req_*, valid/ready): operation 0 writes element
// (row_index, col_index) of A, operation 1 writes one of B, operation 2
// asks for row row_index of C. Writes outside the configured shape and
// operation 3 are taken and dropped without a response.
// Response channel (rsp_*, valid/ready): one word per column of the row,
// columns in ascending order, each the full 40-bit Q10.30 sum of inner_size
// products, with row_last on the final column. A row beyond a_rows gives
// a single word with status set and a zero value.
// A write is carried out at once from idle; a row is started from idle and
// then forms inner_size x b_columns products in the run state, one product
// per cycle while the receiver does not stall. Each word is offered once its
// last product has passed the operand, product and output registers.
// A two-word command queue separates request decoding from execution, so
// requests keep flowing while a result waits, until the queue fills. When
// the receiver stalls, the whole multiply pipeline holds and the waiting word stays stable.
// Reset (synchronous) empties the queue and pipeline and sets all three size
// registers to 16; the element stores are not cleared and must be written
// before they are used. Write sizes via csr_* at idle; the block does not check.
module matrix_multiply_engine_core
   import mme_pkg::*;
#(
   parameter int MAX_DIM = MME_MAX_DIM
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [IDX_W-1:0]          req_row_index,
   input  logic [IDX_W-1:0]          req_col_index,
   input  logic signed [ELEM_W-1:0]  req_element_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [IDX_W-1:0]          rsp_out_row,
   output logic [IDX_W-1:0]          rsp_out_col,
   output logic signed [VALUE_W-1:0] rsp_product_value,
   output logic                      rsp_row_last,
   output logic                      rsp_status,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_write_data
);

   logic [CSR_W-1:0] a_rows_ff;
   logic [CSR_W-1:0] inner_size_ff;
   logic [CSR_W-1:0] b_columns_ff;
   dims_type         dims;

   logic         q_push;
   cmd_type      q_push_cmd;
   logic         q_pop;
   logic         q_valid;
   cmd_type      q_head;
   logic         q_full;
   rsp_word_type rsp_word;

   // Size registers. Writes to the unused index are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff     <= DIM_RESET;
         inner_size_ff <= DIM_RESET;
         b_columns_ff  <= DIM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_A_ROWS:     a_rows_ff     <= csr_write_data;
            CSR_INNER_SIZE: inner_size_ff <= csr_write_data;
            CSR_B_COLUMNS:  b_columns_ff  <= csr_write_data;
            default: begin
               a_rows_ff <= a_rows_ff;
            end
         endcase
      end
   end

   // Effective sizes: zero acts as one and anything above the store size is clamped.
   assign dims.m = eff_dim(a_rows_ff, MAX_DIM);
   assign dims.n = eff_dim(inner_size_ff, MAX_DIM);
   assign dims.o = eff_dim(b_columns_ff, MAX_DIM);

   mme_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .dims              (dims),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (q_push_cmd)
   );

   mme_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head),
      .full       (q_full)
   );

   mme_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims),
      .q_valid   (q_valid),
      .q_cmd     (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_row       = rsp_word.out_row;
   assign rsp_out_col       = rsp_word.out_col;
   assign rsp_product_value = rsp_word.product_value;
   assign rsp_row_last      = rsp_word.row_last;
   assign rsp_status        = rsp_word.status;

endmodule

### tb/mme_tb_pkg.sv
package mme_tb_pkg;

   import mme_pkg::*;

   // Operation code that the engine takes and drops.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   class row_product_scoreboard;

      logic signed [ELEM_W-1:0] a_elem [MME_MAX_DIM * MME_MAX_DIM];
      logic signed [ELEM_W-1:0] b_elem [MME_MAX_DIM * MME_MAX_DIM];
      logic [CSR_W-1:0]         a_rows_raw;
      logic [CSR_W-1:0]         inner_raw;
      logic [CSR_W-1:0]         b_columns_raw;
      rsp_word_type             awaited_words [$];

      int unsigned mismatch_count;
      int unsigned words_checked;
      int unsigned element_writes;
      int unsigned ignored_requests;
      int unsigned row_requests;
      int unsigned refused_rows;

      function new();
         a_rows_raw       = DIM_RESET;
         inner_raw        = DIM_RESET;
         b_columns_raw    = DIM_RESET;
         mismatch_count   = 0;
         words_checked    = 0;
         element_writes   = 0;
         ignored_requests = 0;
         row_requests     = 0;
         refused_rows     = 0;
      endfunction

      // Zero behaves as one and anything above the store size as the store size.
      function int unsigned effective(logic [CSR_W-1:0] raw);
         if (raw == '0) return 1;
         if (int'(raw) > MME_MAX_DIM) return MME_MAX_DIM;
         return int'(raw);
      endfunction

      function int unsigned rows();
         return effective(a_rows_raw);
      endfunction

      function int unsigned inner();
         return effective(inner_raw);
      endfunction

      function int unsigned columns();
         return effective(b_columns_raw);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         case (index)
            CSR_A_ROWS:     a_rows_raw    = value;
            CSR_INNER_SIZE: inner_raw     = value;
            CSR_B_COLUMNS:  b_columns_raw = value;
            default: ;
         endcase
      endfunction

      function bit drained();
         return awaited_words.size() == 0;
      endfunction

      // Applies one accepted request; returns 0 when the engine drops it.
      function bit note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic signed [ELEM_W-1:0] value);
         int unsigned  m;
         int unsigned  n;
         int unsigned  o;
         int unsigned  j;
         int unsigned  k;
         longint       sum;
         rsp_word_type word;
         m = rows();
         n = inner();
         o = columns();
         case (op)
            OP_WRITE_A: begin
               if (row < m && col < n) begin
                  a_elem[int'(row) * MME_MAX_DIM + int'(col)] = value;
                  element_writes++;
                  return 1;
               end
            end
            OP_WRITE_B: begin
               if (row < n && col < o) begin
                  b_elem[int'(row) * MME_MAX_DIM + int'(col)] = value;
                  element_writes++;
                  return 1;
               end
            end
            OP_ROW: begin
               row_requests++;
               if (row >= m) begin
                  refused_rows++;
                  word.out_row       = row;
                  word.out_col       = '0;
                  word.product_value = '0;
                  word.row_last      = 1'b1;
                  word.status        = 1'b1;
                  awaited_words.push_back(word);
                  return 1;
               end
               for (j = 0; j < o; j++) begin
                  sum = 0;
                  for (k = 0; k < n; k++) begin
                     sum += longint'(a_elem[int'(row) * MME_MAX_DIM + k]) *
                            longint'(b_elem[k * MME_MAX_DIM + j]);
                  end
                  word.out_row       = row;
                  word.out_col       = IDX_W'(j);
                  word.product_value = sum[VALUE_W-1:0];
                  word.row_last      = (j + 1 == o);
                  word.status        = 1'b0;
                  awaited_words.push_back(word);
               end
               return 1;
            end
            default: ;
         endcase
         ignored_requests++;
         return 0;
      endfunction

      function void check_word(logic [IDX_W-1:0] out_row, logic [IDX_W-1:0] out_col,
                               logic signed [VALUE_W-1:0] product_value,
                               logic row_last, logic status);
         rsp_word_type want;
         if (awaited_words.size() == 0) begin
            $error("result word for row %0d column %0d arrived with none outstanding",
                   out_row, out_col);
            mismatch_count++;
            return;
         end
         want = awaited_words.pop_front();
         words_checked++;
         if (out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_row);
            mismatch_count++;
         end
         if (out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, out_col);
            mismatch_count++;
         end
         if (product_value !== want.product_value) begin
            $error("product_value: expected %0d, got %0d", want.product_value, product_value);
            mismatch_count++;
         end
         if (row_last !== want.row_last) begin
            $error("row_last: expected %0d, got %0d", want.row_last, row_last);
            mismatch_count++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
         end
      endfunction

   endclass

endpackage

### tb/tb_top.sv
// Drives the matrix multiply engine with element loads, row requests and
// dropped requests over several matrix shapes, and checks every result word
// against a behavioural prediction kept in the scoreboard class.
module tb_top;

   import mme_pkg::*;
   import mme_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A row's first word comes only after its inner sum is complete, and an
   // accepted write can still sit in the two-word queue when the last word
   // arrives, so this many quiet cycles leave the engine truly idle.
   localparam int SETTLE_CYCLES = 48;

   // This limit lies well beyond the slowest correct run.
   localparam realtime RUN_LIMIT = 2ms;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation;
   logic [IDX_W-1:0]          req_row_index;
   logic [IDX_W-1:0]          req_col_index;
   logic signed [ELEM_W-1:0]  req_element_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [IDX_W-1:0]          rsp_out_row;
   logic [IDX_W-1:0]          rsp_out_col;
   logic signed [VALUE_W-1:0] rsp_product_value;
   logic                      rsp_row_last;
   logic                      rsp_status;
   logic                      csr_write_enable;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_W-1:0]          csr_write_data;

   row_product_scoreboard sb;
   bit                    idling_on;
   int unsigned           shapes_run;

   matrix_multiply_engine_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_row_last      (rsp_row_last),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver drops ready in short random bursts while idling is on, and
   // otherwise takes every word as soon as it is offered.
   initial begin
      int unsigned hold;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold != 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 3) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every word taken at an edge goes to the scoreboard. Outputs are read at
   // the edge itself, before the engine's registers move on.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_word(rsp_out_row, rsp_out_col, rsp_product_value, rsp_row_last, rsp_status);
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Element values lean towards the two extremes of Q1.15 now and then.
   function automatic logic signed [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // Offers one word and holds it until taken. Valid is only lowered when an
   // idle burst is chosen, so back-to-back words keep valid high throughout.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col,
                            input logic signed [ELEM_W-1:0] value, output bit took_effect);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_row_index     <= row;
      req_col_index     <= col;
      req_element_value <= value;
      do @(posedge clock); while (!req_ready);
      took_effect = sb.note_request(op, row, col, value);
   endtask

   // The sender stops and waits for every outstanding word. At least one
   // clock passes, so valid is never lowered and raised in the same step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (!sb.drained());
   endtask

   // Reprograms the selected size registers once the engine has gone quiet.
   task automatic reshape(input logic [2:0] which, input logic [CSR_W-1:0] m_raw,
                          input logic [CSR_W-1:0] n_raw, input logic [CSR_W-1:0] o_raw);
      logic [CSR_W-1:0]     raw [3];
      logic [CSR_IDX_W-1:0] idx [3];
      raw = '{m_raw, n_raw, o_raw};
      idx = '{CSR_A_ROWS, CSR_INNER_SIZE, CSR_B_COLUMNS};
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int r = 0; r < 3; r++) begin
         if (which[r]) begin
            csr_write_enable <= 1'b1;
            csr_index        <= idx[r];
            csr_write_data   <= raw[r];
            @(posedge clock);
            sb.set_register(idx[r], raw[r]);
         end
      end
      csr_write_enable <= 1'b0;
      shapes_run++;
   endtask

   // Fills the whole active part of both stores, so that no row request in
   // this shape can touch an entry that was never written.
   task automatic load_shape();
      bit taken;
      for (int r = 0; r < sb.rows(); r++) begin
         for (int c = 0; c < sb.inner(); c++) begin
            send_word(OP_WRITE_A, IDX_W'(r), IDX_W'(c), pick_element(), taken);
         end
      end
      for (int r = 0; r < sb.inner(); r++) begin
         for (int c = 0; c < sb.columns(); c++) begin
            send_word(OP_WRITE_B, IDX_W'(r), IDX_W'(c), pick_element(), taken);
         end
      end
   endtask

   // Mostly row requests and in-shape rewrites, with some out-of-shape
   // writes, rows beyond a_rows and the unused operation mixed in. Dropped
   // requests do not count towards the total.
   task automatic random_mix(input int unsigned count);
      int unsigned      done_items;
      int unsigned      pick;
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      bit               taken;
      done_items = 0;
      while (done_items < count) begin
         pick = $urandom_range(0, 99);
         row  = IDX_W'($urandom);
         col  = IDX_W'($urandom);
         if (pick < 35) begin
            op  = OP_ROW;
            row = IDX_W'($urandom_range(0, sb.rows() - 1));
         end else if (pick < 45) begin
            op = OP_ROW;
         end else if (pick < 70) begin
            op = OP_WRITE_A;
            if (pick < 64) begin
               row = IDX_W'($urandom_range(0, sb.rows() - 1));
               col = IDX_W'($urandom_range(0, sb.inner() - 1));
            end
         end else if (pick < 95) begin
            op = OP_WRITE_B;
            if (pick < 89) begin
               row = IDX_W'($urandom_range(0, sb.inner() - 1));
               col = IDX_W'($urandom_range(0, sb.columns() - 1));
            end
         end else begin
            op = OP_UNUSED;
         end
         send_word(op, row, col, pick_element(), taken);
         if (taken) done_items++;
         if ($urandom_range(0, 39) == 0) drain_results();
      end
   endtask

   initial begin
      bit taken;
      sb                = new();
      idling_on         = 1'b1;
      shapes_run        = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_WRITE_A;
      req_row_index     = '0;
      req_col_index     = '0;
      req_element_value = '0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_A_ROWS;
      csr_write_data    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First shape: one row by one column, with inner_size left at its
      // reset value of 16, so the products show that the reset value holds
      // and every word is the longest inner sum.
      reshape(3'b101, 5'd1, 5'd0, 5'd1);
      load_shape();

      // Directed words: element extremes at the corners of the shape, writes
      // just outside it, the unused operation, and rows both inside and
      // beyond a_rows, the last with every unused field at its maximum.
      send_word(OP_WRITE_A, 4'd0, 4'd0, 16'sh8000, taken);
      send_word(OP_WRITE_B, 4'd0, 4'd0, 16'sh8000, taken);
      send_word(OP_WRITE_A, 4'd0, 4'd15, 16'sh7FFF, taken);
      send_word(OP_WRITE_B, 4'd15, 4'd0, 16'sh7FFF, taken);
      send_word(OP_WRITE_A, 4'd1, 4'd0, 16'sd1234, taken);
      send_word(OP_WRITE_B, 4'd0, 4'd1, 16'sd4321, taken);
      send_word(OP_WRITE_B, 4'd15, 4'd15, -16'sd1, taken);
      send_word(OP_UNUSED, 4'd15, 4'd15, -16'sd1, taken);
      send_word(OP_ROW, 4'd0, 4'd0, 16'sd0, taken);
      send_word(OP_ROW, 4'd1, 4'd0, 16'sd0, taken);
      send_word(OP_ROW, 4'd15, 4'd15, -16'sd1, taken);
      send_word(OP_WRITE_A, 4'd0, 4'd0, 16'sh7FFF, taken);
      send_word(OP_WRITE_B, 4'd0, 4'd0, 16'sh7FFF, taken);
      send_word(OP_ROW, 4'd0, 4'd0, 16'sd0, taken);
      // Let everything drain before the random part, so that the sender is
      // seen to pause with the response side emptying behind it.
      drain_results();
      random_mix(8);

      // A zero a_rows acts as one and 31 columns clamp to sixteen, so each
      // row request gives the most words a request can give.
      reshape(3'b111, 5'd0, 5'd1, 5'd31);
      load_shape();
      random_mix(8);

      // Three rows, an inner size of two and a zero column count acting as one.
      reshape(3'b111, 5'd3, 5'd2, 5'd0);
      load_shape();
      random_mix(8);

      reshape(3'b111, CSR_W'($urandom_range(0, 4)), CSR_W'($urandom_range(0, 4)),
              CSR_W'($urandom_range(0, 4)));
      load_shape();
      random_mix(8);

      // The last stretch runs flat out over all sixteen rows.
      idling_on = 1'b0;
      reshape(3'b111, 5'd16, 5'd1, 5'd2);
      load_shape();
      random_mix(10);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d matrix shapes with %0d element writes and %0d dropped requests.",
               shapes_run, sb.element_writes, sb.ignored_requests);
      $display("%0d row requests (%0d beyond a_rows) gave %0d checked result words.",
               sb.row_requests, sb.refused_rows, sb.words_checked);
      if (sb.mismatch_count == 0 && sb.drained()) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
